// ===== rtl/des_retail_mac_defines.svh =====
// Assertion macros used by the block's top-level RTL file.
`ifndef DES_RETAIL_MAC_DEFINES_SVH
`define DES_RETAIL_MAC_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define DRM_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define DRM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== rtl/drm_pkg.sv =====
`timescale 1ns / 1ps
package drm_pkg;

  localparam int unsigned BlockW = 64;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [3:0] LowMask = 4'h7;

  // Configuration register indexes.
  localparam logic [1:0] RegKeyOne = 2'd0;
  localparam logic [1:0] RegKeyTwo = 2'd1;
  localparam logic [1:0] RegPadMode = 2'd2;

  // Padding modes.
  localparam logic [1:0] PadAlways = 2'd0;
  localparam logic [1:0] PadOptional = 2'd1;
  localparam logic [1:0] PadZeros = 2'd2;
  localparam logic [1:0] PadUnknown = 2'd3;

  typedef struct packed {
    logic [63:0] data_block;
    logic [3:0]  byte_count;
    logic        last_block;
  } drm_in_t;

  typedef struct packed {
    logic [63:0] mac_value;
    logic        status;
  } drm_out_t;

  // Control from the sequencer to the DES round unit.
  typedef struct packed {
    logic        start;
    logic        decrypt;
    logic [63:0] block;
    logic [63:0] key;
  } drm_des_cmd_t;

  localparam logic [7:0] TabIp [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam logic [7:0] TabFp [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam logic [7:0] TabE [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam logic [7:0] TabP [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
  localparam logic [7:0] TabPc1 [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
  localparam logic [7:0] TabPc2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
  localparam logic [1:0] TabRot [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  localparam logic [3:0] TabS [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] perm_ip(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63 - i] = v[64 - int'(TabIp[i])];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63 - i] = v[64 - int'(TabFp[i])];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55 - i] = v[64 - int'(TabPc1[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47 - i] = v[56 - int'(TabPc2[i])];
    return r;
  endfunction

  // One Feistel function evaluation: expand, mix key, S-boxes, permute.
  function automatic logic [31:0] feistel(input logic [31:0] half, input logic [47:0] sub);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] r;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) x[47 - i] = half[32 - int'(TabE[i])];
    x = x ^ sub;
    for (int b = 0; b < 8; b++) begin
      six = x[47 - 6 * b -: 6];
      s[31 - 4 * b -: 4] = TabS[b][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) r[31 - i] = s[32 - int'(TabP[i])];
    return r;
  endfunction

endpackage

// ===== rtl/drm_des_core.sv =====
`timescale 1ns / 1ps
// Iterative DES: one round per cycle, sixteen rounds. Decryption runs the
// key schedule backwards by rotating right, starting from the round-16 key.
module drm_des_core
  import drm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  drm_des_cmd_t cmd_i,
  output logic         done_o,
  output logic [63:0]  result_o
);

  logic        busy_q;
  logic [3:0]  round_q;
  logic        dec_q;
  logic [27:0] c_q, d_q;
  logic [31:0] l_q, r_q;
  logic [27:0] c_d, d_d;
  logic [27:0] c_rd, d_rd;
  logic [55:0] cd_init;
  logic [63:0] ip_init;
  logic [31:0] nr;
  logic [1:0]  rot;

  assign cd_init = perm_pc1(cmd_i.key);
  assign ip_init = perm_ip(cmd_i.block);
  assign rot = dec_q ? TabRot[4'd15 - round_q] : TabRot[round_q];

  // Subkey for this round: encrypt rotates left first, decrypt uses the
  // current key and rotates right afterwards.
  always_comb begin
    c_rd = c_q;
    d_rd = d_q;
    c_d  = c_q;
    d_d  = d_q;
    if (!dec_q) begin
      if (rot == 2'd1) begin
        c_rd = {c_q[26:0], c_q[27]};
        d_rd = {d_q[26:0], d_q[27]};
      end else begin
        c_rd = {c_q[25:0], c_q[27:26]};
        d_rd = {d_q[25:0], d_q[27:26]};
      end
      c_d = c_rd;
      d_d = d_rd;
    end else begin
      if (rot == 2'd1) begin
        c_d = {c_q[0], c_q[27:1]};
        d_d = {d_q[0], d_q[27:1]};
      end else begin
        c_d = {c_q[1:0], c_q[27:2]};
        d_d = {d_q[1:0], d_q[27:2]};
      end
    end
  end

  assign nr = l_q ^ feistel(r_q, perm_pc2({c_rd, d_rd}));

  // Round sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      round_q <= '0;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (cmd_i.start) begin
        busy_q  <= 1'b1;
        round_q <= '0;
      end else if (busy_q) begin
        round_q <= round_q + 4'd1;
        if (round_q == 4'd15) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // Datapath registers; the rotation of the key by 28 places total lands
  // the decrypt start on the round-16 key, which equals the PC1 output.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dec_q <= cmd_i.decrypt;
      c_q   <= cd_init[55:28];
      d_q   <= cd_init[27:0];
      l_q   <= ip_init[63:32];
      r_q   <= ip_init[31:0];
    end else if (busy_q) begin
      c_q <= c_d;
      d_q <= d_d;
      l_q <= r_q;
      r_q <= nr;
    end
  end

  assign result_o = perm_fp({r_q, l_q});

endmodule

// ===== rtl/des_retail_mac.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// in       input      in_valid_i/in_stall_o  drm_in_t
// out      output     out_valid_o/out_stall_i drm_out_t
// cfg      input      cfg_valid_i/cfg_ready_o index, data
// A block that is not last is accepted, started on the shared round unit, run
// through sixteen DES rounds, and its result is stored as the chain.
// A last block runs up to four DES passes (data, 80h marker, D_K2, E_K1),
// then waits until the result is taken.
// Reset clears keys, pad mode, chain and control; the output waits while
// out_stall_i is high and no new item is accepted meanwhile.
module des_retail_mac
  import drm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  drm_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output drm_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

`include "des_retail_mac_defines.svh"

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StData  = 6'b000010,
    StMark  = 6'b000100,
    StDec   = 6'b001000,
    StEnc   = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  state_e       state_q, state_d;
  logic [63:0]  key_one_q, key_two_q, chain_q;
  logic [1:0]   pad_mode_q;
  logic         wait_q;
  logic         last_q, mark_q;
  logic [63:0]  blk_q;
  drm_out_t     out_q;
  drm_des_cmd_t cmd;
  logic         des_done;
  logic [63:0]  des_res;
  logic [3:0]   n_sat;
  logic [63:0]  keep, padded;
  logic         acc;

  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (state_q == StOut);
  assign out_data_o  = out_q;
  assign acc = in_valid_i && !in_stall_o;

  // Padding of the last block.
  always_comb begin
    n_sat  = (in_data_i.byte_count > 4'd8) ? 4'd8 : in_data_i.byte_count;
    keep   = ~64'd0 << (7'd64 - {n_sat, 3'b000});
    if (n_sat == 4'd0) keep = '0;
    padded = in_data_i.data_block & keep;
    if (pad_mode_q != PadZeros && (n_sat & LowMask) != 4'd0)
      padded = padded | ({PadByte, 56'd0} >> {n_sat, 3'b000});
  end

  drm_des_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .done_o   (des_done),
    .result_o (des_res)
  );

  // Config writes, chain and state registers; one DES pass per phase, wait_q marks a pass in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      wait_q     <= 1'b0;
      key_one_q  <= '0;
      key_two_q  <= '0;
      pad_mode_q <= PadAlways;
      chain_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegKeyOne:  key_one_q  <= cfg_data_i;
          RegKeyTwo:  key_two_q  <= cfg_data_i;
          RegPadMode: pad_mode_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (cmd.start) wait_q <= 1'b1;
      if (des_done) wait_q <= 1'b0;
      if (state_q == StData && des_done) chain_q <= des_res;
      if (state_q == StMark && des_done) chain_q <= des_res;
      if (state_q == StEnc && des_done) chain_q <= '0;
      if (acc && in_data_i.last_block && pad_mode_q == PadUnknown) chain_q <= '0;
      state_q <= state_d;
    end
  end

  // Item capture and result register. The final encrypt input is the
  // decrypt result, held in blk_q.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      last_q <= in_data_i.last_block;
      blk_q  <= in_data_i.last_block ? padded : in_data_i.data_block;
      mark_q <= in_data_i.last_block && pad_mode_q == PadAlways
                && (n_sat == 4'd8 || n_sat == 4'd0);
      if (in_data_i.last_block && pad_mode_q == PadUnknown) out_q <= '{64'd0, 1'b1};
    end
    if (state_q == StDec && des_done) blk_q <= des_res;
    if (state_q == StEnc && des_done) out_q <= '{des_res, 1'b0};
  end

  always_comb begin
    state_d = state_q;
    cmd = '{1'b0, 1'b0, 64'd0, key_one_q};
    case (state_q)
      StIdle: begin
        if (acc) begin
          if (in_data_i.last_block && pad_mode_q == PadUnknown) state_d = StOut;
          else if (in_data_i.last_block && n_sat == 4'd0) begin
            state_d = (pad_mode_q == PadAlways) ? StMark : StDec;
          end else state_d = StData;
        end
      end
      StData: begin
        cmd = '{!wait_q, 1'b0, chain_q ^ blk_q, key_one_q};
        if (des_done) state_d = !last_q ? StIdle : (mark_q ? StMark : StDec);
      end
      StMark: begin
        cmd = '{!wait_q, 1'b0, chain_q ^ {PadByte, 56'd0}, key_one_q};
        if (des_done) state_d = StDec;
      end
      StDec: begin
        cmd = '{!wait_q, 1'b1, chain_q, key_two_q};
        if (des_done) state_d = StEnc;
      end
      StEnc: begin
        cmd = '{!wait_q, 1'b0, blk_q, key_one_q};
        if (des_done) state_d = StOut;
      end
      StOut: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  `DRM_ASSERT_IMP(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `DRM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(out_data_o))
  `DRM_ASSERT_IMP(a_no_start_busy, clk_i, rst_ni, cmd.start, !wait_q)

endmodule
